>>> rtl/srlr_pkg.sv
// Shared types and constants for the stereo ring linear resampler.
// Used by srlr_lane and stereo_ring_linear_resampler; no dependencies.
package srlr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAME_W    = 2 * SAMPLE_W;
  localparam int MIX_W      = 32;
  localparam int STEP_W     = 18;
  localparam int VOL_W      = 8;
  localparam int FILL_W     = 12;
  localparam int CFG_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int DIGIT_W    = 8;
  localparam int MIX_DIGITS = MIX_W / DIGIT_W;

  localparam logic [STEP_W-1:0] STEP_RESET = 18'd16384;
  localparam logic [VOL_W-1:0]  VOL_RESET  = 8'd255;

  // func field codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO_SOURCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ENABLE = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_UNDERRUN = 2'd2,
    ST_DISABLED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_CUR,
    S_RD_NXT,
    S_LOAD,
    S_LERP,
    S_VLOAD,
    S_VOL,
    S_ALOAD,
    S_ADD,
    S_RESULT
  } state_t;

  // sequencer -> lane commands, at most one active per cycle (take_mix aside)
  typedef struct packed {
    logic take_mix;
    logic load;
    logic lerp_step;
    logic vol_load;
    logic vol_step;
    logic add_load;
    logic add_step;
  } lane_ctrl_t;

endpackage

>>> rtl/stereo_ring_linear_resampler.sv
// Top level: stereo frame ring with fractional-rate linear interpolation.
// Depends on srlr_pkg, srlr_ring and srlr_lane.
//
//  channel | handshake          | beat contents
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | func, sample_left/right, mix_left/right
//  out     | out_valid/out_stall| out_left/right, status_code, fill_level
//  cfg     | cfg_we             | cfg_index, cfg_data (write only)
//
// A push, a full-ring push, a disabled pull and an underrun go straight from
// idle to the result state. A served pull runs two single-port RAM reads,
// FRAC_BITS bit-serial lerp steps, VOL_W volume steps
// and MIX_DIGITS byte steps of the mix add.
// One beat is in flight at a time; in_stall is high while it is worked on.
// The finished beat sits in the output register; a new input beat is taken
// while it waits, and the sequencer holds its next result until it drains.
// Reset is synchronous. The RAM needs no clearing pass: a pull reads only
// frames between the read and write pointers, all written since reset.
// RING_DEPTH must be a power of two.
module stereo_ring_linear_resampler #(
  parameter int RING_DEPTH = 4096,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic signed [srlr_pkg::SAMPLE_W-1:0] sample_left,
  input  logic signed [srlr_pkg::SAMPLE_W-1:0] sample_right,
  input  logic signed [srlr_pkg::MIX_W-1:0]    mix_left,
  input  logic signed [srlr_pkg::MIX_W-1:0]    mix_right,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [srlr_pkg::MIX_W-1:0]    out_left,
  output logic signed [srlr_pkg::MIX_W-1:0]    out_right,
  output logic [1:0]                          status_code,
  output logic [srlr_pkg::FILL_W-1:0]          fill_level,

  input  logic                                cfg_we,
  input  logic [srlr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srlr_pkg::CFG_W-1:0]           cfg_data
);

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int PW     = AW + FRAC_BITS;                 // phase accumulator
  localparam int SW     = srlr_pkg::SAMPLE_W;
  localparam int STW    = srlr_pkg::STEP_W;
  localparam int ADDW   = ((FRAC_BITS > STW) ? FRAC_BITS : STW) + 1;
  localparam int ADVW   = ADDW - FRAC_BITS;
  localparam int CW     = ((ADVW > AW) ? ADVW : AW) + 1;
  localparam int EW     = (PW > STW) ? PW : STW;
  localparam int FXW    = (AW > srlr_pkg::FILL_W) ? AW : srlr_pkg::FILL_W;
  localparam int MAXS   = (FRAC_BITS > srlr_pkg::VOL_W) ? FRAC_BITS : srlr_pkg::VOL_W;
  localparam int CNT_W  = $clog2(MAXS);

  // config registers
  logic [STW-1:0]              phase_step;
  logic [srlr_pkg::VOL_W-1:0]  volume;
  logic                        mono_source;
  logic                        play_enable;

  // ring state
  logic [AW-1:0]               wp;
  logic [AW-1:0]               rp;
  logic [PW-1:0]               phase;

  srlr_pkg::state_t            state, state_next;
  srlr_pkg::status_t           res_status, res_status_next;
  srlr_pkg::status_t           out_status;
  srlr_pkg::lane_ctrl_t        ctrl;
  logic [CNT_W-1:0]            cnt;
  logic [srlr_pkg::FRAME_W-1:0] cur_word;

  logic                        accept;
  logic                        full;
  logic                        fits;
  logic                        advance_en;
  logic                        result_load;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [srlr_pkg::FRAME_W-1:0] mem_wdata;
  logic [srlr_pkg::FRAME_W-1:0] mem_rdata;

  logic [AW-1:0]               fill;
  logic [FXW-1:0]              fill_ext;
  logic [ADDW-1:0]             adv_sum;
  logic [CW-1:0]               adv_plus1;
  logic [PW-1:0]               np;
  logic [SW-1:0]               right_in;
  logic [srlr_pkg::MIX_W-1:0]  take_left, take_right;
  logic [srlr_pkg::MIX_W-1:0]  sum_left, sum_right;

  assign in_stall = (state != srlr_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // pointer arithmetic, all modulo the ring size
  always_comb begin
    fill      = wp - rp;
    fill_ext  = FXW'(fill);
    full      = ((wp + AW'(1)) == rp);
    adv_sum   = ADDW'(phase[FRAC_BITS-1:0]) + ADDW'(phase_step);
    adv_plus1 = CW'(adv_sum[ADDW-1:FRAC_BITS]) + CW'(1);
    fits      = (adv_plus1 < CW'(fill));  // next frame strictly before wp
    np        = PW'(EW'(phase) + EW'(phase_step));
    right_in  = mono_source ? sample_left : sample_right;
    mem_wdata = {right_in, sample_left};
    take_left  = (func == srlr_pkg::FUNC_PULL) ? mix_left  : '0;
    take_right = (func == srlr_pkg::FUNC_PULL) ? mix_right : '0;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    ctrl            = '0;
    mem_we          = 1'b0;
    mem_addr        = rp;
    advance_en      = 1'b0;
    result_load     = 1'b0;
    unique case (state)
      srlr_pkg::S_IDLE: begin
        mem_addr = wp;
        if (accept) begin
          ctrl.take_mix = 1'b1;
          if (func == srlr_pkg::FUNC_PUSH) begin
            if (full) begin
              res_status_next = srlr_pkg::ST_FULL;
            end else begin
              mem_we          = 1'b1;
              res_status_next = srlr_pkg::ST_OK;
            end
            state_next = srlr_pkg::S_RESULT;
          end else if (!play_enable) begin
            res_status_next = srlr_pkg::ST_DISABLED;
            state_next      = srlr_pkg::S_RESULT;
          end else if (fits) begin
            advance_en      = 1'b1;
            res_status_next = srlr_pkg::ST_OK;
            state_next      = srlr_pkg::S_RD_CUR;
          end else begin
            res_status_next = srlr_pkg::ST_UNDERRUN;
            state_next      = srlr_pkg::S_RESULT;
          end
        end
      end
      srlr_pkg::S_RD_CUR: begin
        mem_addr   = rp;
        state_next = srlr_pkg::S_RD_NXT;
      end
      srlr_pkg::S_RD_NXT: begin
        mem_addr   = rp + AW'(1);
        state_next = srlr_pkg::S_LOAD;
      end
      srlr_pkg::S_LOAD: begin
        ctrl.load  = 1'b1;
        state_next = srlr_pkg::S_LERP;
      end
      srlr_pkg::S_LERP: begin
        ctrl.lerp_step = 1'b1;
        if (cnt == '0) begin
          state_next = srlr_pkg::S_VLOAD;
        end
      end
      srlr_pkg::S_VLOAD: begin
        ctrl.vol_load = 1'b1;
        state_next    = srlr_pkg::S_VOL;
      end
      srlr_pkg::S_VOL: begin
        ctrl.vol_step = 1'b1;
        if (cnt == '0) begin
          state_next = srlr_pkg::S_ALOAD;
        end
      end
      srlr_pkg::S_ALOAD: begin
        ctrl.add_load = 1'b1;
        state_next    = srlr_pkg::S_ADD;
      end
      srlr_pkg::S_ADD: begin
        ctrl.add_step = 1'b1;
        if (cnt == '0) begin
          state_next = srlr_pkg::S_RESULT;
        end
      end
      srlr_pkg::S_RESULT: begin
        if (!out_valid || !out_stall) begin
          result_load = 1'b1;
          state_next  = srlr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srlr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= srlr_pkg::S_IDLE;
      wp          <= '0;
      rp          <= '0;
      phase       <= '0;
      phase_step  <= srlr_pkg::STEP_RESET;
      volume      <= srlr_pkg::VOL_RESET;
      mono_source <= 1'b0;
      play_enable <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          srlr_pkg::CFG_PHASE_STEP:  phase_step  <= cfg_data[STW-1:0];
          srlr_pkg::CFG_VOLUME:      volume      <= cfg_data[srlr_pkg::VOL_W-1:0];
          srlr_pkg::CFG_MONO_SOURCE: mono_source <= cfg_data[0];
          srlr_pkg::CFG_PLAY_ENABLE: play_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (mem_we) begin
        wp <= wp + AW'(1);
      end
      if (advance_en) begin
        phase <= np;
        rp    <= np[PW-1:FRAC_BITS];
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    if (state == srlr_pkg::S_RD_NXT) begin
      cur_word <= mem_rdata;
    end
    unique case (state)
      srlr_pkg::S_LOAD:  cnt <= CNT_W'(FRAC_BITS - 1);
      srlr_pkg::S_VLOAD: cnt <= CNT_W'(srlr_pkg::VOL_W - 1);
      srlr_pkg::S_ALOAD: cnt <= CNT_W'(srlr_pkg::MIX_DIGITS - 1);
      default:           cnt <= cnt - CNT_W'(1);
    endcase
    if (result_load) begin
      out_left   <= sum_left;
      out_right  <= sum_right;
      out_status <= res_status;
      fill_level <= fill_ext[srlr_pkg::FILL_W-1:0];
    end
  end

  assign status_code = out_status;

  srlr_ring #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (AW),
    .DATA_W (srlr_pkg::FRAME_W)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // left lives in the low half of a frame, right in the high half
  srlr_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_left (
    .clk    (clk),
    .ctrl   (ctrl),
    .cur    (cur_word[SW-1:0]),
    .nxt    (mem_rdata[SW-1:0]),
    .frac   (phase[FRAC_BITS-1:0]),
    .volume (volume),
    .mix    (take_left),
    .sum    (sum_left)
  );

  srlr_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_right (
    .clk    (clk),
    .ctrl   (ctrl),
    .cur    (cur_word[2*SW-1:SW]),
    .nxt    (mem_rdata[2*SW-1:SW]),
    .frac   (phase[FRAC_BITS-1:0]),
    .volume (volume),
    .mix    (take_right),
    .sum    (sum_right)
  );

endmodule

>>> rtl/srlr_ring.sv
// Frame store of the resampler: single-port RAM, registered read.
// No package dependency; instantiated by stereo_ring_linear_resampler.
module srlr_ring #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/srlr_lane.sv
// One channel datapath: bit-serial lerp multiply, bit-serial volume
// multiply, byte-serial 32-bit mix add. Depends on srlr_pkg.
module srlr_lane #(
  parameter int FRAC_BITS = 14
) (
  input  logic                           clk,
  input  srlr_pkg::lane_ctrl_t           ctrl,
  input  logic [srlr_pkg::SAMPLE_W-1:0]  cur,
  input  logic [srlr_pkg::SAMPLE_W-1:0]  nxt,
  input  logic [FRAC_BITS-1:0]           frac,
  input  logic [srlr_pkg::VOL_W-1:0]     volume,
  input  logic [srlr_pkg::MIX_W-1:0]     mix,
  output logic [srlr_pkg::MIX_W-1:0]     sum
);

  localparam int SW    = srlr_pkg::SAMPLE_W;
  localparam int ACC_W = SW + 1;
  localparam int VW    = srlr_pkg::VOL_W;
  localparam int MW    = srlr_pkg::MIX_W;
  localparam int DW    = srlr_pkg::DIGIT_W;
  localparam int PRD_W = SW + VW;

  logic [SW-1:0]        a;
  logic [SW-1:0]        l;
  logic [ACC_W-1:0]     d;
  logic [ACC_W-1:0]     acc;
  logic [FRAC_BITS-1:0] frac_sr;
  logic [VW-1:0]        vol_sr;
  logic [MW-1:0]        prod_sr;
  logic [MW-1:0]        mix_sr;
  logic                 carry;

  logic [ACC_W:0]  sum_lerp;
  logic [ACC_W:0]  sum_vol;
  logic [DW:0]     dsum;
  logic [PRD_W-1:0] product;

  // acc = (acc + bit ? addend : 0) >>> 1 ; after n steps acc = floor(x*m / 2^n)
  always_comb begin
    sum_lerp = {acc[ACC_W-1], acc} + (frac_sr[0] ? {d[ACC_W-1], d} : '0);
    sum_vol  = {acc[ACC_W-1], acc} + (vol_sr[0] ? {{2{l[SW-1]}}, l} : '0);
    dsum     = {1'b0, mix_sr[DW-1:0]} + {1'b0, prod_sr[DW-1:0]} + {{DW{1'b0}}, carry};
    product  = {acc[SW-1:0], vol_sr};
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_mix) begin
      mix_sr <= mix;
    end
    if (ctrl.load) begin
      a       <= cur;
      d       <= {nxt[SW-1], nxt} - {cur[SW-1], cur};
      acc     <= '0;
      frac_sr <= frac;
    end else if (ctrl.lerp_step) begin
      acc     <= sum_lerp[ACC_W:1];
      frac_sr <= frac_sr >> 1;
    end else if (ctrl.vol_load) begin
      // interpolated sample always lies between cur and nxt
      l      <= a + acc[SW-1:0];
      acc    <= '0;
      vol_sr <= volume;
    end else if (ctrl.vol_step) begin
      acc    <= sum_vol[ACC_W:1];
      vol_sr <= {sum_vol[0], vol_sr[VW-1:1]};
    end else if (ctrl.add_load) begin
      prod_sr <= {{(MW - PRD_W){product[PRD_W-1]}}, product};
      carry   <= 1'b0;
    end else if (ctrl.add_step) begin
      mix_sr  <= {dsum[DW-1:0], mix_sr[MW-1:DW]};
      prod_sr <= prod_sr >> DW;
      carry   <= dsum[DW];
    end
  end

  assign sum = mix_sr;

endmodule
